### rtl/qsgt_pkg.sv
// Shared constants, request types and state encodings for the grace tracker.
package qsgt_pkg;

  localparam int THREADS = 64;
  localparam int IDX_W   = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 6;
  localparam int EPOCH_W = 64;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHECKPOINT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BARRIER    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SYNC       = 3'd4;

  typedef enum logic [2:0] {
    OP_REGISTER,
    OP_UNREGISTER,
    OP_CHECKPOINT,
    OP_BARRIER,
    OP_SYNC,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               in_range;
    logic [IDX_W-1:0]   idx;
    logic [EPOCH_W-1:0] target;
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_REPLY
  } state_t;

endpackage

### rtl/qsgt_front.sv
// Front stage: accept requests, decode the command and range-check the slot.
module qsgt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qsgt_pkg::CMD_W-1:0]    command,
  input  logic [qsgt_pkg::SLOT_W-1:0]   thread_slot,
  input  logic [qsgt_pkg::EPOCH_W-1:0]  target_epoch,
  output logic                          q_valid,
  input  logic                          q_ready,
  output qsgt_pkg::req_t                q_req
);
  import qsgt_pkg::*;

  logic hold_valid;
  req_t hold;
  req_t hold_next;

  always_comb begin
    hold_next.in_range = (32'(thread_slot) < THREADS);
    hold_next.idx      = IDX_W'(thread_slot);
    hold_next.target   = target_epoch;
    unique case (command)
      CMD_REGISTER:   hold_next.op = OP_REGISTER;
      CMD_UNREGISTER: hold_next.op = OP_UNREGISTER;
      CMD_CHECKPOINT: hold_next.op = OP_CHECKPOINT;
      CMD_BARRIER:    hold_next.op = OP_BARRIER;
      CMD_SYNC:       hold_next.op = OP_SYNC;
      default:        hold_next.op = OP_NOP;
    endcase
  end

  assign in_ready = !hold_valid || q_ready;
  assign q_valid  = hold_valid;
  assign q_req    = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= hold_next;
    end
  end

endmodule

### rtl/qsgt_fifo.sv
// Short request queue between the front stage and the execution stage.
module qsgt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  qsgt_pkg::req_t wr_req,
  output logic           rd_valid,
  input  logic           rd_ready,
  output qsgt_pkg::req_t rd_req
);
  import qsgt_pkg::*;

  req_t              entries [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_req   = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      unique case ({push, pop})
        2'b10:   count <= QCNT_W'(count + 1'b1);
        2'b01:   count <= QCNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_req;
    end
  end

endmodule

### rtl/qsgt_back.sv
// Execution stage: slot table, global epoch, sync scan and result register.
module qsgt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  qsgt_pkg::req_t                q_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qsgt_pkg::EPOCH_W-1:0]  epoch_out,
  output logic                          grace_done,
  output logic                          status
);
  import qsgt_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [EPOCH_W-1:0]   epoch;
  logic [THREADS-1:0]   slot_valid;
  logic [EPOCH_W-1:0]   mem [0:THREADS-1];
  logic [EPOCH_W-1:0]   rd_data;
  logic [IDX_W-1:0]     scan_idx;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_pend;
  logic                 fail;
  logic [EPOCH_W-1:0]   sync_target;

  logic                 out_free;
  logic                 slot_ok;
  logic                 load_out;
  logic [EPOCH_W-1:0]   ld_epoch;
  logic                 ld_done;
  logic                 ld_status;
  logic                 mem_we;
  logic [EPOCH_W-1:0]   mem_wd;
  logic                 set_valid;
  logic                 clr_valid;
  logic                 epoch_inc;
  logic                 scan_start;
  logic                 scan_step;

  assign out_free = !out_valid || out_ready;
  assign slot_ok  = q_req.in_range && slot_valid[q_req.idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    load_out   = 1'b0;
    ld_epoch   = epoch;
    ld_done    = 1'b0;
    ld_status  = 1'b0;
    mem_we     = 1'b0;
    mem_wd     = epoch;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    epoch_inc  = 1'b0;
    scan_start = 1'b0;
    scan_step  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_ready = 1'b1;
          unique case (q_req.op)
            OP_REGISTER: begin
              load_out  = 1'b1;
              ld_status = !q_req.in_range;
              mem_we    = q_req.in_range;
              mem_wd    = '0;
              set_valid = q_req.in_range;
            end
            OP_UNREGISTER: begin
              load_out  = 1'b1;
              ld_status = !slot_ok;
              clr_valid = slot_ok;
            end
            OP_CHECKPOINT: begin
              load_out  = 1'b1;
              ld_status = !slot_ok;
              mem_we    = slot_ok;
            end
            OP_BARRIER: begin
              load_out  = 1'b1;
              epoch_inc = 1'b1;
              ld_epoch  = EPOCH_W'(epoch + 1'b1);
            end
            OP_SYNC: begin
              if (slot_ok) begin
                mem_we     = 1'b1;
                scan_start = 1'b1;
                state_next = ST_SCAN;
              end else begin
                load_out  = 1'b1;
                ld_status = 1'b1;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        scan_step = 1'b1;
        if (scan_idx == IDX_W'(THREADS - 1)) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_REPLY;
      end
      ST_REPLY: begin
        if (out_free) begin
          load_out   = 1'b1;
          ld_done    = !fail;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch      <= EPOCH_W'(1);
      slot_valid <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (epoch_inc) begin
        epoch <= EPOCH_W'(epoch + 1'b1);
      end
      if (set_valid) begin
        slot_valid[q_req.idx] <= 1'b1;
      end
      if (clr_valid) begin
        slot_valid[q_req.idx] <= 1'b0;
      end
      rd_pend <= scan_step;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_req.idx] <= mem_wd;
    end
    rd_data <= mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      scan_idx    <= '0;
      fail        <= 1'b0;
      sync_target <= q_req.target;
    end else begin
      if (scan_step) begin
        rd_idx   <= scan_idx;
        scan_idx <= IDX_W'(scan_idx + 1'b1);
      end
      if (rd_pend && slot_valid[rd_idx] && (rd_data < sync_target)) begin
        fail <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      epoch_out  <= ld_epoch;
      grace_done <= ld_done;
      status     <= ld_status;
    end
  end

endmodule

### rtl/quiescent_state_grace_tracker_top.sv
// Top level of the quiescent-state grace tracker.
// Requests enter a decode register, wait in a two-entry queue and are then
// executed against the slot table; each request yields exactly one result.
// Register, unregister, checkpoint, barrier and unknown commands complete in
// the idle state of the execution stage, so these flow at one request per cycle
// while results are taken. Sync writes the caller's checkpoint and then
// reads the slot epoch memory one slot per cycle through its single read
// port, then passes through ST_LAST and ST_REPLY. The front keeps
// accepting requests into the queue while a sync scan runs, until it fills.
module quiescent_state_grace_tracker_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qsgt_pkg::CMD_W-1:0]    command,
  input  logic [qsgt_pkg::SLOT_W-1:0]   thread_slot,
  input  logic [qsgt_pkg::EPOCH_W-1:0]  target_epoch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qsgt_pkg::EPOCH_W-1:0]  epoch_out,
  output logic                          grace_done,
  output logic                          status
);
  import qsgt_pkg::*;

  logic f_valid;
  logic f_ready;
  req_t f_req;
  logic b_valid;
  logic b_ready;
  req_t b_req;

  qsgt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .thread_slot  (thread_slot),
    .target_epoch (target_epoch),
    .q_valid      (f_valid),
    .q_ready      (f_ready),
    .q_req        (f_req)
  );

  qsgt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_req   (f_req),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_req   (b_req)
  );

  qsgt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_req      (b_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .epoch_out  (epoch_out),
    .grace_done (grace_done),
    .status     (status)
  );

endmodule

### tb/quiescent_state_grace_tracker_top_tb.sv
// Testbench for the quiescent-state grace tracker: directed table plus random traffic.
`timescale 1ns / 1ps

module quiescent_state_grace_tracker_top_tb;
  import qsgt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NOP_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NOP_C = 3'd7;
  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_NOSLOT = 1'b1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  localparam int ITEMS     = 1250;
  localparam int PLAN_LEN  = 25;
  localparam int HOLD_AT   = 400;
  localparam int HOLD_LEN  = 500;
  localparam int DRAIN     = 2 * THREADS + 20;
  localparam int MAX_CYCLES = 1000000;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic               done;
    logic               stat;
  } reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  slot;
    logic [EPOCH_W-1:0] target;
    logic               typed;
    reply_t             want;
  } row_t;

  localparam row_t PLAN [PLAN_LEN] = '{
    '{CMD_SYNC,       6'd5,  64'd0,     1'b1, '{64'd1, 1'b0, STAT_NOSLOT}},
    '{CMD_UNREGISTER, 6'd63, EPOCH_MAX, 1'b1, '{64'd1, 1'b0, STAT_NOSLOT}},
    '{CMD_CHECKPOINT, 6'd0,  64'd0,     1'b1, '{64'd1, 1'b0, STAT_NOSLOT}},
    '{CMD_NOP_A,      6'd0,  64'd0,     1'b1, '{64'd1, 1'b0, STAT_OK}},
    '{CMD_NOP_B,      6'd21, 64'd0,     1'b1, '{64'd1, 1'b0, STAT_OK}},
    '{CMD_NOP_C,      6'd42, EPOCH_MAX, 1'b1, '{64'd1, 1'b0, STAT_OK}},
    '{CMD_REGISTER,   6'd0,  64'd0,     1'b1, '{64'd1, 1'b0, STAT_OK}},
    '{CMD_REGISTER,   6'd63, EPOCH_MAX, 1'b1, '{64'd1, 1'b0, STAT_OK}},
    '{CMD_BARRIER,    6'd0,  64'd0,     1'b1, '{64'd2, 1'b0, STAT_OK}},
    '{CMD_SYNC,       6'd0,  64'd0,     1'b1, '{64'd2, 1'b1, STAT_OK}},
    '{CMD_SYNC,       6'd0,  64'd2,     1'b1, '{64'd2, 1'b0, STAT_OK}},
    '{CMD_CHECKPOINT, 6'd63, 64'd0,     1'b0, '0},
    '{CMD_SYNC,       6'd63, 64'd2,     1'b0, '0},
    '{CMD_REGISTER,   6'd0,  64'd0,     1'b0, '0},
    '{CMD_SYNC,       6'd63, 64'd1,     1'b0, '0},
    '{CMD_UNREGISTER, 6'd0,  64'd0,     1'b0, '0},
    '{CMD_SYNC,       6'd63, EPOCH_MAX, 1'b1, '{64'd2, 1'b0, STAT_OK}},
    '{CMD_SYNC,       6'd63, 64'd2,     1'b0, '0},
    '{CMD_BARRIER,    6'd63, EPOCH_MAX, 1'b1, '{64'd3, 1'b0, STAT_OK}},
    '{CMD_CHECKPOINT, 6'd0,  64'd0,     1'b1, '{64'd3, 1'b0, STAT_NOSLOT}},
    '{CMD_UNREGISTER, 6'd63, 64'd0,     1'b0, '0},
    '{CMD_SYNC,       6'd63, 64'd0,     1'b1, '{64'd3, 1'b0, STAT_NOSLOT}},
    '{CMD_REGISTER,   6'd42, EPOCH_MAX, 1'b0, '0},
    '{CMD_CHECKPOINT, 6'd42, 64'd0,     1'b0, '0},
    '{CMD_SYNC,       6'd42, 64'd3,     1'b0, '0}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [CMD_W-1:0]   command;
  logic [SLOT_W-1:0]  thread_slot;
  logic [EPOCH_W-1:0] target_epoch;
  logic               out_valid;
  logic               out_ready;
  logic [EPOCH_W-1:0] epoch_out;
  logic               grace_done;
  logic               status;

  logic [EPOCH_W-1:0] cur_epoch = EPOCH_W'(1);
  bit                 tbl_valid [THREADS];
  logic [EPOCH_W-1:0] tbl_epoch [THREADS];

  reply_t pending [$];
  int     errors = 0;
  int     accepted = 0;
  int     burst_left = 0;

  quiescent_state_grace_tracker_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .thread_slot  (thread_slot),
    .target_epoch (target_epoch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .epoch_out    (epoch_out),
    .grace_done   (grace_done),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic reply_t apply_request(input logic [CMD_W-1:0] c,
                                           input logic [SLOT_W-1:0] s,
                                           input logic [EPOCH_W-1:0] t);
    reply_t r;
    bit     live;
    r.done = 1'b0;
    r.stat = STAT_OK;
    live = (s < THREADS) && tbl_valid[s];
    case (c)
      CMD_REGISTER: begin
        if (s < THREADS) begin
          tbl_valid[s] = 1'b1;
          tbl_epoch[s] = '0;
        end else begin
          r.stat = STAT_NOSLOT;
        end
      end
      CMD_UNREGISTER: begin
        if (live) begin
          tbl_valid[s] = 1'b0;
          tbl_epoch[s] = '0;
        end else begin
          r.stat = STAT_NOSLOT;
        end
      end
      CMD_CHECKPOINT: begin
        if (live) tbl_epoch[s] = cur_epoch;
        else r.stat = STAT_NOSLOT;
      end
      CMD_BARRIER: begin
        cur_epoch = cur_epoch + 1'b1;
      end
      CMD_SYNC: begin
        if (live) begin
          tbl_epoch[s] = cur_epoch;
          r.done = 1'b1;
          for (int i = 0; i < THREADS; i++)
            if (tbl_valid[i] && tbl_epoch[i] < t) r.done = 1'b0;
        end else begin
          r.stat = STAT_NOSLOT;
        end
      end
      default: ;
    endcase
    r.epoch = cur_epoch;
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] any_live_slot();
    int live [$];
    for (int i = 0; i < THREADS; i++)
      if (tbl_valid[i]) live.push_back(i);
    if (live.size() == 0) return SLOT_W'($urandom_range(0, THREADS - 1));
    return SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < THREADS; i++)
      if (tbl_valid[i]) n++;
    return n;
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
                              input logic [EPOCH_W-1:0] t, input logic typed,
                              input reply_t typed_reply);
    reply_t r;
    int     gap;
    in_valid     <= 1'b1;
    command      <= c;
    thread_slot  <= s;
    target_epoch <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_request(c, s, t);
    pending.push_back(typed ? typed_reply : r);
    accepted++;
    // pace the sender: bursts, then an optional gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    int                 sent;
    int                 roll;
    int                 pool_base;
    logic [CMD_W-1:0]   c;
    logic [SLOT_W-1:0]  s;
    logic [EPOCH_W-1:0] t;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    command      <= CMD_REGISTER;
    thread_slot  <= '0;
    target_epoch <= '0;
    sent = 0;
    pool_base = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < PLAN_LEN; k++)
      send_request(PLAN[k].cmd, PLAN[k].slot, PLAN[k].target, PLAN[k].typed, PLAN[k].want);

    while (sent < ITEMS) begin
      if (sent % 150 == 0) pool_base = $urandom_range(0, 7) * 8;
      if ($urandom_range(0, 11) == 0) begin
        // grace period: advance, every live slot checks in, then sync on the new epoch
        send_request(CMD_BARRIER, SLOT_W'($urandom), {$urandom, $urandom}, 1'b0, '0);
        sent++;
        if (live_count() == 0) begin
          send_request(CMD_REGISTER, SLOT_W'($urandom), {$urandom, $urandom}, 1'b0, '0);
          sent++;
        end
        for (int i = 0; i < THREADS; i++) begin
          if (tbl_valid[i]) begin
            send_request(CMD_CHECKPOINT, SLOT_W'(i), {$urandom, $urandom}, 1'b0, '0);
            sent++;
          end
        end
        send_request(CMD_SYNC, any_live_slot(), cur_epoch, 1'b0, '0);
        sent++;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 12) c = CMD_REGISTER;
        else if (roll < 22) c = CMD_UNREGISTER;
        else if (roll < 47) c = CMD_CHECKPOINT;
        else if (roll < 65) c = CMD_BARRIER;
        else if (roll < 95) c = CMD_SYNC;
        else c = CMD_NOP_A + CMD_W'($urandom_range(0, 2));

        roll = $urandom_range(0, 9);
        if (roll < 6 && live_count() > 0) s = any_live_slot();
        else if (roll < 9) s = SLOT_W'(pool_base + $urandom_range(0, 7));
        else s = SLOT_W'($urandom_range(0, THREADS - 1));

        t = {$urandom, $urandom};
        if (c == CMD_SYNC) begin
          roll = $urandom_range(0, 9);
          if (roll == 0) t = '0;
          else if (roll == 1) t = EPOCH_MAX;
          else if (roll < 6) t = cur_epoch;
          else if (roll == 6) t = cur_epoch + 1'b1;
          else if (roll < 10) t = cur_epoch - EPOCH_W'($urandom_range(1, 4));
        end

        send_request(c, s, t, 1'b0, '0);
        if (c <= CMD_SYNC) sent++;
      end
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : receiver
    int  mode;
    int  span;
    int  held;
    int  tick;
    bit  hold_done;
    out_ready <= 1'b0;
    hold_done = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (!hold_done && accepted >= HOLD_AT) begin
          // hold off long enough for the queue to fill and stall the input
          hold_done = 1'b1;
          out_ready <= 1'b0;
          held = 0;
          while (held < HOLD_LEN) begin
            @(posedge clk);
            held++;
          end
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= (tick % 5 > 1);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t: result with none pending: epoch %0d done %0b status %0b",
                 $time, epoch_out, grace_done, status);
        errors++;
      end else begin
        want = pending.pop_front();
        if (epoch_out !== want.epoch) begin
          $display("%0t: epoch_out expected %0d actual %0d", $time, want.epoch, epoch_out);
          errors++;
        end
        if (grace_done !== want.done) begin
          $display("%0t: grace_done expected %0b actual %0b", $time, want.done, grace_done);
          errors++;
        end
        if (status !== want.stat) begin
          $display("%0t: status expected %0b actual %0b", $time, want.stat, status);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < MAX_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

endmodule
